### hw/rtl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// shared types and constants of the fat12 boot sector classifier
// ----------------------------------------------------------------------------
`default_nettype none

package fbc_pkg;

  localparam int SECTOR_BYTES_DEFAULT = 512;

  // fixed offsets of the boot parameter fields
  localparam int OFS_BPS_LO   = 'h0B;
  localparam int OFS_BPS_HI   = 'h0C;
  localparam int OFS_SPC      = 'h0D;
  localparam int OFS_RES_LO   = 'h0E;
  localparam int OFS_RES_HI   = 'h0F;
  localparam int OFS_FATS     = 'h10;
  localparam int OFS_ROOT_LO  = 'h11;
  localparam int OFS_ROOT_HI  = 'h12;
  localparam int OFS_TOTS_LO  = 'h13;
  localparam int OFS_TOTS_HI  = 'h14;
  localparam int OFS_FATSZ_LO = 'h16;
  localparam int OFS_FATSZ_HI = 'h17;
  localparam int OFS_TOTL_B0  = 'h20;
  localparam int OFS_TOTL_B1  = 'h21;
  localparam int OFS_TOTL_B2  = 'h22;
  localparam int OFS_TOTL_B3  = 'h23;
  localparam int OFS_SIG_LO   = 510;
  localparam int OFS_SIG_HI   = 511;

  localparam logic [7:0]  SIG_LO_VALUE  = 8'h55;
  localparam logic [7:0]  SIG_HI_VALUE  = 8'hAA;
  localparam logic [31:0] FAT12_MAX_CLUSTERS = 32'd4085;

  typedef enum logic [2:0] {
    VERDICT_FAT12     = 3'd0,
    VERDICT_BAD_SIG   = 3'd1,
    VERDICT_BAD_GEOM  = 3'd2,
    VERDICT_ZERO_FAT  = 3'd3,
    VERDICT_TOO_MANY  = 3'd4
  } verdict_t;

  // controller to datapath
  typedef struct packed {
    logic take;    // accept one sector byte
    logic check;   // run field checks, product and root sectors
    logic sum;     // add up overhead sectors
    logic divide;  // data sectors, cluster count, load result
  } fbc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_byte;
  } fbc_stat_t;

endpackage

`default_nettype wire

### hw/rtl/fbc_ctrl.sv
// ----------------------------------------------------------------------------
// fbc_ctrl
// sequencer: byte intake, then three verdict steps, then a result strobe
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_ctrl import fbc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire fbc_stat_t stat,
  output fbc_cmd_t       cmd,
  output logic           busy,
  output logic           done
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_SUM    = 4'b0100,
    S_DIVIDE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.take   = start && (state == S_IDLE);
    cmd.check  = (state == S_CHECK);
    cmd.sum    = (state == S_SUM);
    cmd.divide = (state == S_DIVIDE);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.take && stat.last_byte) state_next = S_CHECK;
      end
      S_CHECK:  state_next = S_SUM;
      S_SUM:    state_next = S_DIVIDE;
      S_DIVIDE: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_DIVIDE);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fbc_datapath.sv
// ----------------------------------------------------------------------------
// fbc_datapath
// byte position, field capture and the staged cluster arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_datapath import fbc_pkg::*; #(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire fbc_cmd_t  cmd,
  input  wire logic [7:0] sector_byte,
  input  wire logic      first_byte,
  output fbc_stat_t      stat,
  output logic [2:0]     verdict,
  output logic [31:0]    cluster_count
);

  localparam int POS_W = $clog2(SECTOR_BYTES + 1);
  localparam logic [POS_W-1:0] POS_END  = POS_W'(SECTOR_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(SECTOR_BYTES - 1);

  // log2 of a one-hot value, meaningful only when one bit is set
  function automatic logic [3:0] onehot_log2(input logic [15:0] v);
    logic [3:0] idx;
    idx = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) idx = idx | 4'(i);
    end
    return idx;
  endfunction

  function automatic logic pow2_nonzero(input logic [15:0] v);
    return (v != '0) && ((v & (v - 16'd1)) == '0);
  endfunction

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] pos_eff;
  logic             in_range;

  logic [15:0] bytes_per_sector;
  logic [7:0]  sectors_per_cluster;
  logic [15:0] reserved_sectors;
  logic [7:0]  fat_copies;
  logic [15:0] root_entries;
  logic [15:0] total_sectors_small;
  logic [15:0] fat_sectors;
  logic [31:0] total_sectors_large;
  logic [7:0]  signature_low;
  logic        sig_high_ok;

  // check step results
  verdict_t    early_verdict;
  logic [23:0] fat_area;
  logic [21:0] root_sectors;
  logic [31:0] total_sectors;
  logic [2:0]  spc_shift;
  // sum step result
  logic [24:0] overhead;

  logic [21:0] root_bytes_up;
  logic [31:0] data_sectors;
  logic [31:0] clusters;
  verdict_t    verdict_chk;

  assign pos_eff        = first_byte ? '0 : byte_position;
  assign in_range       = (pos_eff < POS_END);
  assign stat.last_byte = (pos_eff == POS_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      bytes_per_sector    <= '0;
      sectors_per_cluster <= '0;
      reserved_sectors    <= '0;
      fat_copies          <= '0;
      root_entries        <= '0;
      total_sectors_small <= '0;
      fat_sectors         <= '0;
      total_sectors_large <= '0;
      signature_low       <= '0;
      sig_high_ok         <= 1'b0;
    end else if (cmd.take && in_range) begin
      byte_position <= pos_eff + 1'b1;
      case (pos_eff)
        POS_W'(OFS_BPS_LO):   bytes_per_sector[7:0]     <= sector_byte;
        POS_W'(OFS_BPS_HI):   bytes_per_sector[15:8]    <= sector_byte;
        POS_W'(OFS_SPC):      sectors_per_cluster       <= sector_byte;
        POS_W'(OFS_RES_LO):   reserved_sectors[7:0]     <= sector_byte;
        POS_W'(OFS_RES_HI):   reserved_sectors[15:8]    <= sector_byte;
        POS_W'(OFS_FATS):     fat_copies                <= sector_byte;
        POS_W'(OFS_ROOT_LO):  root_entries[7:0]         <= sector_byte;
        POS_W'(OFS_ROOT_HI):  root_entries[15:8]        <= sector_byte;
        POS_W'(OFS_TOTS_LO):  total_sectors_small[7:0]  <= sector_byte;
        POS_W'(OFS_TOTS_HI):  total_sectors_small[15:8] <= sector_byte;
        POS_W'(OFS_FATSZ_LO): fat_sectors[7:0]          <= sector_byte;
        POS_W'(OFS_FATSZ_HI): fat_sectors[15:8]         <= sector_byte;
        POS_W'(OFS_TOTL_B0):  total_sectors_large[7:0]  <= sector_byte;
        POS_W'(OFS_TOTL_B1):  total_sectors_large[15:8] <= sector_byte;
        POS_W'(OFS_TOTL_B2):  total_sectors_large[23:16] <= sector_byte;
        POS_W'(OFS_TOTL_B3):  total_sectors_large[31:24] <= sector_byte;
        POS_W'(OFS_SIG_LO):   signature_low             <= sector_byte;
        POS_W'(OFS_SIG_HI):   sig_high_ok <= (sector_byte == SIG_HI_VALUE);
        default: ;
      endcase
    end
  end

  // round up root directory bytes to whole sectors
  assign root_bytes_up = {1'b0, root_entries, 5'b0} + {6'b0, bytes_per_sector - 16'd1};

  always_comb begin
    if ((signature_low != SIG_LO_VALUE) || !sig_high_ok) begin
      verdict_chk = VERDICT_BAD_SIG;
    end else if (!pow2_nonzero(bytes_per_sector) ||
                 !pow2_nonzero({8'd0, sectors_per_cluster})) begin
      verdict_chk = VERDICT_BAD_GEOM;
    end else if (fat_sectors == '0) begin
      verdict_chk = VERDICT_ZERO_FAT;
    end else begin
      verdict_chk = VERDICT_FAT12;
    end
  end

  assign data_sectors = total_sectors - {7'd0, overhead};
  assign clusters     = data_sectors >> spc_shift;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      early_verdict <= verdict_chk;
      fat_area      <= {16'd0, fat_copies} * {8'd0, fat_sectors};
      root_sectors  <= root_bytes_up >> onehot_log2(bytes_per_sector);
      total_sectors <= (total_sectors_small != '0) ? {16'd0, total_sectors_small}
                                                   : total_sectors_large;
      spc_shift     <= 3'(onehot_log2({8'd0, sectors_per_cluster}));
    end
    if (cmd.sum) begin
      overhead <= {9'd0, reserved_sectors} + {1'b0, fat_area} + {3'd0, root_sectors};
    end
    if (cmd.divide) begin
      if (early_verdict != VERDICT_FAT12) begin
        verdict       <= early_verdict;
        cluster_count <= '0;
      end else begin
        verdict       <= (clusters >= FAT12_MAX_CLUSTERS) ? VERDICT_TOO_MANY
                                                          : VERDICT_FAT12;
        cluster_count <= clusters;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fat12_boot_sector_classifier.sv
// the verdict strobe follows the last sector byte through the check, sum and divide states
// throughput: one byte per cycle while busy is low; busy is high after the last byte
//   of each sector, while the sequencer runs its check, sum and divide states
// the next sector's first byte is taken in the same cycle as the strobe
// reset: synchronous, clears the byte position, captured fields and the sequencer
// the receiver cannot stall: done is high for exactly one cycle per result
// ----------------------------------------------------------------------------
// fat12_boot_sector_classifier
// takes a boot sector one byte per beat, captures the boot parameter fields,
// and after the last byte reports whether the volume is fat12
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_boot_sector_classifier import fbc_pkg::*; #(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte intake: a beat is taken when start is high and busy is low
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  sector_byte,
  input  wire logic        first_byte,
  // verdict: valid for the single cycle that done is high
  output logic             done,
  output logic [2:0]       verdict,
  output logic [31:0]      cluster_count
);

  fbc_cmd_t  cmd;
  fbc_stat_t stat;

  // controller: idle takes bytes, then check, sum and divide steps
  fbc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath: position counter, field registers, staged arithmetic
  // bytes per sector and sectors per cluster are checked as powers of two,
  // so both divisions become shifts by the one-hot bit index
  fbc_datapath #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sector_byte   (sector_byte),
    .first_byte    (first_byte),
    .stat          (stat),
    .verdict       (verdict),
    .cluster_count (cluster_count)
  );

endmodule

`default_nettype wire
